[rtl/core/quadratic_root_solver_top_macros.svh]
// Assertion macros used by the quadratic root solver top level.
`ifndef QUADRATIC_ROOT_SOLVER_TOP_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside of reset.
`define QRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the following cycle, checked on the rising clock edge outside of reset.
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/qrs_pkg.sv]
// Shared constants and types of the quadratic root solver.
package qrs_pkg;

    localparam int COEF_WIDTH = 16;
    localparam int FRAC_BITS  = 16;
    localparam int ROOT_WIDTH = 35;

    typedef enum logic [1:0] {
        ST_TWO    = 2'd0,
        ST_DOUBLE = 2'd1,
        ST_NONE   = 2'd2,
        ST_AZERO  = 2'd3
    } t_status;

endpackage

[rtl/core/qrs_stream_if.sv]
// Valid/ready channel interfaces for coefficient beats and root beats.
interface qrs_coef_if #(
    parameter int CW = qrs_pkg::COEF_WIDTH
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] coef_a;
    logic signed [CW-1:0] coef_b;
    logic signed [CW-1:0] coef_c;

    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_root_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             root_status;
    logic signed [qrs_pkg::ROOT_WIDTH-1:0]  root_plus;
    logic signed [qrs_pkg::ROOT_WIDTH-1:0]  root_minus;

    modport source (output valid, root_status, root_plus, root_minus, input ready);
    modport sink   (input valid, root_status, root_plus, root_minus, output ready);
endinterface

[rtl/core/qrs_isqrt.sv]
// Pipelined digit-by-digit integer square root, one result bit per stage.
module qrs_isqrt #(
    parameter int RW = 66,
    parameter int TW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RW-1:0]     i_rad,
    input  logic [TW-1:0]     i_tag,
    output logic              o_valid,
    output logic [RW/2-1:0]   o_root,
    output logic [TW-1:0]     o_tag
);
    localparam int SW = RW / 2;
    localparam int MW = SW + 2;

    logic [SW-1:0] r_vld;
    logic [MW-1:0] r_rem  [SW];
    logic [MW-1:0] n_rem  [SW];
    logic [SW-1:0] r_root [SW];
    logic [SW-1:0] n_root [SW];
    logic [RW-1:0] r_rad  [SW];
    logic [RW-1:0] n_rad  [SW];
    logic [TW-1:0] r_tag  [SW];
    logic [TW-1:0] n_tag  [SW];

    always_comb begin
        logic [MW-1:0] p_rem;
        logic [SW-1:0] p_root;
        logic [RW-1:0] p_rad;
        logic [MW+1:0] acc;
        logic [MW+1:0] trial;
        for (int k = 0; k < SW; k++) begin
            if (k == 0) begin
                p_rem    = '0;
                p_root   = '0;
                p_rad    = i_rad;
                n_tag[k] = i_tag;
            end else begin
                p_rem    = r_rem[k-1];
                p_root   = r_root[k-1];
                p_rad    = r_rad[k-1];
                n_tag[k] = r_tag[k-1];
            end
            acc   = {p_rem, p_rad[RW-1 -: 2]};
            trial = (MW+2)'({p_root, 2'b01});
            if (acc >= trial) begin
                n_rem[k]  = MW'(acc - trial);
                n_root[k] = {p_root[SW-2:0], 1'b1};
            end else begin
                n_rem[k]  = acc[MW-1:0];
                n_root[k] = {p_root[SW-2:0], 1'b0};
            end
            n_rad[k] = {p_rad[RW-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= n_rad[k];
                r_tag[k]  <= n_tag[k];
            end
        end
    end

    assign o_valid = r_vld[SW-1];
    assign o_root  = r_root[SW-1];
    assign o_tag   = r_tag[SW-1];

endmodule

[rtl/core/qrs_div.sv]
// Pipelined signed restoring divider, truncating toward zero, one quotient bit per stage.
module qrs_div #(
    parameter int NW = 35,
    parameter int DW = 17,
    parameter int TW = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    input  logic [TW-1:0]        i_tag,
    output logic                 o_valid,
    output logic signed [NW-1:0] o_quo,
    output logic [TW-1:0]        o_tag
);
    logic [NW+1:0] r_vld;

    logic [NW-1:0] r0_q;
    logic [DW-1:0] r0_d;
    logic          r0_neg;
    logic [TW-1:0] r0_tag;

    logic [NW-1:0] r_q   [NW];
    logic [NW-1:0] n_q   [NW];
    logic [DW-1:0] r_rem [NW];
    logic [DW-1:0] n_rem [NW];
    logic [DW-1:0] r_d   [NW];
    logic [DW-1:0] n_d   [NW];
    logic          r_neg [NW];
    logic          n_neg [NW];
    logic [TW-1:0] r_tag [NW];
    logic [TW-1:0] n_tag [NW];

    logic signed [NW-1:0] r_quo;
    logic [TW-1:0]        r_otag;

    always_comb begin
        logic [NW-1:0] p_q;
        logic [DW-1:0] p_rem;
        logic [DW:0]   acc;
        for (int k = 0; k < NW; k++) begin
            if (k == 0) begin
                p_q      = r0_q;
                p_rem    = '0;
                n_d[k]   = r0_d;
                n_neg[k] = r0_neg;
                n_tag[k] = r0_tag;
            end else begin
                p_q      = r_q[k-1];
                p_rem    = r_rem[k-1];
                n_d[k]   = r_d[k-1];
                n_neg[k] = r_neg[k-1];
                n_tag[k] = r_tag[k-1];
            end
            acc = {p_rem, p_q[NW-1]};
            if (acc >= {1'b0, n_d[k]}) begin
                n_rem[k] = DW'(acc - {1'b0, n_d[k]});
                n_q[k]   = {p_q[NW-2:0], 1'b1};
            end else begin
                n_rem[k] = acc[DW-1:0];
                n_q[k]   = {p_q[NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NW:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_q   <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r0_d   <= i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
            r0_neg <= i_num[NW-1] ^ i_den[DW-1];
            r0_tag <= i_tag;
            for (int k = 0; k < NW; k++) begin
                r_q[k]   <= n_q[k];
                r_rem[k] <= n_rem[k];
                r_d[k]   <= n_d[k];
                r_neg[k] <= n_neg[k];
                r_tag[k] <= n_tag[k];
            end
            r_quo  <= r_neg[NW-1] ? $signed(-r_q[NW-1]) : $signed(r_q[NW-1]);
            r_otag <= r_tag[NW-1];
        end
    end

    assign o_valid = r_vld[NW+1];
    assign o_quo   = r_quo;
    assign o_tag   = r_otag;

endmodule

[rtl/core/quadratic_root_solver_top.sv]
// Top level of the pipelined quadratic root solver.
//
// A coefficient beat (a, b, c) enters on i_coef; one root beat per coefficient
// beat leaves on o_root in the same order. The root beat carries a status and
// two signed fixed-point roots with FRAC_BITS fraction bits. Status 0 gives two
// distinct roots, 1 a double root in both fields, 2 no real roots and 3 a zero
// leading coefficient; for status 2 and 3 both roots are zero.
// The pipeline takes one beat in every cycle unless o_root stalls it. A beat passes
// the product register, the discriminant register, the square root stages, the
// numerator register, the divider stages and the output register in that order.
// The square root and divider stages each produce one result bit per stage.
// All stages advance together: when the receiver holds o_root.ready low with a
// beat waiting, the whole pipeline holds and i_coef.ready goes low, so nothing
// is lost or repeated. Reset clears all valid bits; no beat is in flight after
// reset and the block is ready at once.
module quadratic_root_solver_top #(
    parameter int CW = qrs_pkg::COEF_WIDTH,
    parameter int FB = qrs_pkg::FRAC_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    qrs_coef_if.sink       i_coef,
    qrs_root_if.source     o_root
);
    import qrs_pkg::*;

    `include "quadratic_root_solver_top_macros.svh"

    localparam int DW   = 2 * CW + 1;
    localparam int RADW = DW + 2 * FB;
    localparam int RW   = RADW + (RADW % 2);
    localparam int SW   = RW / 2;
    localparam int BW   = CW + FB;
    localparam int NW   = ((BW > SW) ? BW : SW) + 2;
    localparam int DENW = CW + 1;
    localparam int TW   = 2 + NW + DENW;
    localparam int OW   = ROOT_WIDTH;
    localparam int XW   = (NW > OW) ? NW : OW;

    logic en;

    logic            r1_vld;
    logic [2*CW-1:0] r1_bb;
    logic [2*CW-1:0] r1_acm;
    logic            r1_az;
    logic            r1_sa;
    logic            r1_sc;
    logic            r1_sb;
    logic [CW-1:0]   r1_bmag;
    logic [CW-1:0]   r1_a;

    logic [CW-1:0] mag_a;
    logic [CW-1:0] mag_b;
    logic [CW-1:0] mag_c;

    logic [2*CW+1:0] bbx;
    logic [2*CW+1:0] four_ac;
    logic [2*CW+1:0] d_sum;
    logic [2*CW+1:0] d_dif;
    logic            add_case;
    logic [DW-1:0]   d_val;
    t_status         n2_status;
    logic [NW-1:0]   nb_mag;

    logic                   r2_vld;
    logic [DW-1:0]          r2_d;
    t_status                r2_status;
    logic signed [NW-1:0]   r2_nb;
    logic signed [DENW-1:0] r2_den;

    logic                   sq_vld;
    logic [SW-1:0]          sq_root;
    logic [TW-1:0]          sq_tag;
    logic [1:0]             sq_status;
    logic signed [NW-1:0]   sq_nb;
    logic signed [DENW-1:0] sq_den;

    logic                   r3_vld;
    logic signed [NW-1:0]   r3_nump;
    logic signed [NW-1:0]   r3_numm;
    logic signed [DENW-1:0] r3_den;
    logic [1:0]             r3_status;

    logic                 dp_vld;
    logic signed [NW-1:0] dp_quo;
    logic [1:0]           dp_status;
    logic                 dm_vld;
    logic signed [NW-1:0] dm_quo;
    logic [1:0]           dm_status;

    logic signed [XW-1:0] x_plus;
    logic signed [XW-1:0] x_minus;
    logic                 zero_roots;

    logic                 r_out_vld;
    logic [1:0]           r_out_status;
    logic signed [OW-1:0] r_out_plus;
    logic signed [OW-1:0] r_out_minus;

    assign en           = !r_out_vld || o_root.ready;
    assign i_coef.ready = en;

    assign mag_a = i_coef.coef_a[CW-1] ? CW'(-i_coef.coef_a) : CW'(i_coef.coef_a);
    assign mag_b = i_coef.coef_b[CW-1] ? CW'(-i_coef.coef_b) : CW'(i_coef.coef_b);
    assign mag_c = i_coef.coef_c[CW-1] ? CW'(-i_coef.coef_c) : CW'(i_coef.coef_c);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_bb   <= mag_b * mag_b;
            r1_acm  <= mag_a * mag_c;
            r1_az   <= (i_coef.coef_a == '0);
            r1_sa   <= i_coef.coef_a[CW-1];
            r1_sc   <= i_coef.coef_c[CW-1];
            r1_sb   <= i_coef.coef_b[CW-1];
            r1_bmag <= mag_b;
            r1_a    <= i_coef.coef_a;
        end
    end

    always_comb begin
        bbx      = (2*CW+2)'(r1_bb);
        four_ac  = {r1_acm, 2'b00};
        d_sum    = bbx + four_ac;
        d_dif    = bbx - four_ac;
        add_case = (r1_sa != r1_sc) && (r1_acm != '0);
        d_val    = add_case ? DW'(d_sum) : DW'(d_dif);
        if (r1_az) begin
            n2_status = ST_AZERO;
        end else if (!add_case && (bbx < four_ac)) begin
            n2_status = ST_NONE;
        end else if (d_val == '0) begin
            n2_status = ST_DOUBLE;
        end else begin
            n2_status = ST_TWO;
        end
        nb_mag = NW'(r1_bmag) << FB;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_d      <= d_val;
            r2_status <= n2_status;
            r2_nb     <= r1_sb ? $signed(nb_mag) : $signed(-nb_mag);
            r2_den    <= $signed({r1_a, 1'b0});
        end
    end

    qrs_isqrt #(
        .RW (RW),
        .TW (TW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_vld),
        .i_rad   (RW'(r2_d) << (2 * FB)),
        .i_tag   ({r2_status, r2_nb, r2_den}),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_tag   (sq_tag)
    );

    assign {sq_status, sq_nb, sq_den} = sq_tag;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_nump   <= sq_nb + $signed(NW'(sq_root));
            r3_numm   <= sq_nb - $signed(NW'(sq_root));
            r3_den    <= sq_den;
            r3_status <= sq_status;
        end
    end

    qrs_div #(
        .NW (NW),
        .DW (DENW),
        .TW (2)
    ) u_div_plus (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_vld),
        .i_num   (r3_nump),
        .i_den   (r3_den),
        .i_tag   (r3_status),
        .o_valid (dp_vld),
        .o_quo   (dp_quo),
        .o_tag   (dp_status)
    );

    qrs_div #(
        .NW (NW),
        .DW (DENW),
        .TW (2)
    ) u_div_minus (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_vld),
        .i_num   (r3_numm),
        .i_den   (r3_den),
        .i_tag   (r3_status),
        .o_valid (dm_vld),
        .o_quo   (dm_quo),
        .o_tag   (dm_status)
    );

    assign x_plus     = XW'(dp_quo);
    assign x_minus    = XW'(dm_quo);
    assign zero_roots = (dp_status == ST_NONE) || (dp_status == ST_AZERO);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r1_vld    <= i_coef.valid;
            r2_vld    <= r1_vld;
            r3_vld    <= sq_vld;
            r_out_vld <= dp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_status <= dp_status;
            r_out_plus   <= zero_roots ? '0 : x_plus[OW-1:0];
            r_out_minus  <= zero_roots ? '0 : x_minus[OW-1:0];
        end
    end

    assign o_root.valid       = r_out_vld;
    assign o_root.root_status = r_out_status;
    assign o_root.root_plus   = r_out_plus;
    assign o_root.root_minus  = r_out_minus;

    `QRS_ASSERT_NOW(a_div_lockstep, dp_vld || dm_vld,
        (dp_vld == dm_vld) && (dp_status == dm_status), "Dividers out of step.")
    `QRS_ASSERT_NOW(a_zero_roots,
        o_root.valid && ((o_root.root_status == ST_NONE) || (o_root.root_status == ST_AZERO)),
        (o_root.root_plus == '0) && (o_root.root_minus == '0), "Roots not cleared.")
    `QRS_ASSERT_NOW(a_double_root, o_root.valid && (o_root.root_status == ST_DOUBLE),
        o_root.root_plus == o_root.root_minus, "Double root fields differ.")
    `QRS_ASSERT_NOW(a_stall_only_full, !i_coef.ready, o_root.valid,
        "Input stalled with no beat waiting.")

endmodule

[bench/tb.sv]
// Self-checking testbench of the quadratic root solver with its own root predictor.
`timescale 1ns / 100ps

module tb;
    import qrs_pkg::*;

    typedef struct {
        t_status                       st;
        logic signed [ROOT_WIDTH-1:0]  rp;
        logic signed [ROOT_WIDTH-1:0]  rm;
    } t_roots;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    qrs_coef_if coef_if ();
    qrs_root_if root_if ();

    quadratic_root_solver_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (coef_if.sink),
        .o_root  (root_if.source)
    );

    always #1 i_clk = ~i_clk;

    t_roots pending_roots[$];
    int     send_idle_pct  = 0;
    int     stall_pct      = 0;
    int     hold_token     = 0;
    int     hold_seen      = 0;
    int     hold_left      = 0;
    int     mismatch_cnt   = 0;
    int     beats_in       = 0;
    int     beats_out      = 0;
    int     azero_cnt      = 0;
    int     none_cnt       = 0;
    int     double_cnt     = 0;
    int     two_cnt        = 0;

    function automatic longint isqrt_wide(logic [127:0] n);
        logic [127:0] res;
        logic [127:0] bt;
        logic [127:0] t;
        res = '0;
        bt = 128'd1 << 126;
        for (int i = 0; i < 64; i++) begin
            t = res + bt;
            if (n >= t) begin
                n = n - t;
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return longint'(res[63:0]);
    endfunction

    function automatic t_roots solve_roots(logic signed [COEF_WIDTH-1:0] a,
                                           logic signed [COEF_WIDTH-1:0] b,
                                           logic signed [COEF_WIDTH-1:0] c);
        t_roots       r;
        longint       sa;
        longint       sb;
        longint       sc;
        longint       disc;
        longint       nb;
        longint       den;
        longint       s;
        logic [127:0] rad;
        sa = a;
        sb = b;
        sc = c;
        r.st = ST_AZERO;
        r.rp = '0;
        r.rm = '0;
        if (sa == 0) return r;
        disc = sb * sb - 4 * sa * sc;
        if (disc < 0) begin
            r.st = ST_NONE;
            return r;
        end
        nb = -(sb * (64'sd1 <<< FRAC_BITS));
        den = 2 * sa;
        if (disc == 0) begin
            r.st = ST_DOUBLE;
            r.rp = ROOT_WIDTH'(nb / den);
            r.rm = r.rp;
            return r;
        end
        rad = 128'(disc) << (2 * FRAC_BITS);
        s = isqrt_wide(rad);
        r.st = ST_TWO;
        r.rp = ROOT_WIDTH'((nb + s) / den);
        r.rm = ROOT_WIDTH'((nb - s) / den);
        return r;
    endfunction

    // Receiver: random stalls, plus a long hold-off whenever the test asks for one.
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= 400;
            root_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            root_if.ready <= 1'b0;
        end else begin
            root_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_roots exp_r;
        if (i_rst_n && root_if.valid && root_if.ready) begin
            beats_out++;
            if (pending_roots.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("Unexpected root beat at %0t", $realtime);
            end else begin
                exp_r = pending_roots.pop_front();
                if (root_if.root_status !== exp_r.st || root_if.root_plus !== exp_r.rp
                        || root_if.root_minus !== exp_r.rm) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("Exp st=%0d p=%0d m=%0d, got st=%0d p=%0d m=%0d",
                                 exp_r.st, exp_r.rp, exp_r.rm, root_if.root_status,
                                 root_if.root_plus, root_if.root_minus);
                end
            end
        end
    end

    task automatic send_coefs(logic signed [COEF_WIDTH-1:0] a,
                              logic signed [COEF_WIDTH-1:0] b,
                              logic signed [COEF_WIDTH-1:0] c);
        t_roots r;
        coef_if.valid  <= 1'b1;
        coef_if.coef_a <= a;
        coef_if.coef_b <= b;
        coef_if.coef_c <= c;
        do @(posedge i_clk); while (!coef_if.ready);
        r = solve_roots(a, b, c);
        pending_roots.push_back(r);
        beats_in++;
        case (r.st)
            ST_AZERO:  azero_cnt++;
            ST_NONE:   none_cnt++;
            ST_DOUBLE: double_cnt++;
            default:   two_cnt++;
        endcase
        while ($urandom_range(99) < send_idle_pct) begin
            coef_if.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        coef_if.valid <= 1'b0;
        while (pending_roots.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic send_random_set();
        int kind;
        int r;
        int q;
        int sg;
        kind = $urandom_range(99);
        if (kind < 10) begin
            send_coefs(0, COEF_WIDTH'($urandom), COEF_WIDTH'($urandom));
        end else if (kind < 22) begin
            r = $urandom_range(1, 30);
            q = $urandom_range(0, 30);
            sg = $urandom_range(1) ? -1 : 1;
            send_coefs(COEF_WIDTH'(sg * r),
                       COEF_WIDTH'(($urandom_range(1) ? 2 : -2) * r * q),
                       COEF_WIDTH'(sg * r * q * q));
        end else if (kind < 60) begin
            send_coefs(COEF_WIDTH'($urandom), COEF_WIDTH'($urandom),
                       COEF_WIDTH'($urandom));
        end else begin
            send_coefs(COEF_WIDTH'($urandom_range(511) - 256),
                       COEF_WIDTH'($urandom_range(511) - 256),
                       COEF_WIDTH'($urandom_range(511) - 256));
        end
    endtask

    task automatic test_directed();
        send_coefs(0, 5, 7);
        send_coefs(0, 0, 0);
        send_coefs(0, -32768, 32767);
        send_coefs(1, -3, 2);
        send_coefs(1, 0, 1);
        send_coefs(1, 2, 1);
        send_coefs(-1, 2, -1);
        send_coefs(1, 0, 0);
        send_coefs(2, 0, -1);
        send_coefs(-3, 7, 5);
        send_coefs(32767, 32767, 32767);
        send_coefs(-32768, -32768, -32768);
        send_coefs(32767, -32768, -32768);
        send_coefs(-32768, 32767, 32767);
        send_coefs(1, -32768, -32768);
        send_coefs(-1, -32768, 32767);
        send_coefs(1, 32767, 0);
        send_coefs(-32768, 0, 32767);
        send_coefs(32767, 0, -32768);
        send_coefs(1, -32768, 0);
        send_coefs(5, 1, -3);
        send_coefs(-7, -2, 9);
        wait_drained();
    endtask

    task automatic test_random_phase(int idle_pct, int stall, int n);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        repeat (n) send_random_set();
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_token++;
        repeat (150) send_random_set();
        wait_drained();
    endtask

    initial begin
        coef_if.valid  = 1'b0;
        coef_if.coef_a = '0;
        coef_if.coef_b = '0;
        coef_if.coef_c = '0;
        root_if.ready  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(0, 0, 250);
        test_random_phase(60, 0, 250);
        test_random_phase(0, 60, 250);
        test_random_phase(17, 17, 250);
        test_backpressure();
        $display("Sent %0d coefficient beats, checked %0d root beats.", beats_in, beats_out);
        $display("Status mix: %0d two roots, %0d double, %0d none, %0d zero a.",
                 two_cnt, double_cnt, none_cnt, azero_cnt);
        if (mismatch_cnt == 0 && pending_roots.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
